@@ hw/rtl/pcolenc_pkg.sv @@
package pcolenc_pkg;

  // Palette size and the width of the palette pointer.
  localparam int unsigned PALETTE_ENTRIES = 512;
  localparam int unsigned PTR_W           = 9;

  // Width of one palette entry.
  localparam int unsigned ENTRY_W = 9;

  // Register select codes.
  localparam logic [2:0] REG_CTRL    = 3'd0;
  localparam logic [2:0] REG_PTR_LO  = 3'd2;
  localparam logic [2:0] REG_PTR_HI  = 3'd3;
  localparam logic [2:0] REG_DATA_LO = 3'd4;
  localparam logic [2:0] REG_DATA_HI = 3'd5;

  // Access kinds.
  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // Fixed read values and frame lengths.
  localparam logic [7:0] RDATA_IDLE    = 8'hFF;
  localparam logic [7:0] RDATA_HI_BASE = 8'hFE;
  localparam logic [8:0] LINES_LONG    = 9'd263;
  localparam logic [8:0] LINES_SHORT   = 9'd262;

  // Divider select codes.
  localparam logic [1:0] DIV_SEL_4 = 2'd0;
  localparam logic [1:0] DIV_SEL_3 = 2'd1;

  // Controller states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_we;
    logic accept;
    logic exec;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic out_hold;
  } status_t;

  // Maps the divider select code to the dot clock divider.
  function automatic logic [2:0] divider_value(input logic [1:0] sel);
    logic [2:0] val;
    case (sel)
      DIV_SEL_4: val = 3'd4;
      DIV_SEL_3: val = 3'd3;
      default:   val = 3'd2;
    endcase
    return val;
  endfunction

endpackage

@@ hw/rtl/pcolenc_ctrl.sv @@
module pcolenc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  pcolenc_pkg::status_t status,
  output logic                in_stall,
  output pcolenc_pkg::cmd_t    cmd
);

  pcolenc_pkg::state_t state_r;
  pcolenc_pkg::state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pcolenc_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state: clear the palette, then alternate between taking a
  // transaction and committing it.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pcolenc_pkg::ST_CLEAR: begin
        if (status.clr_last) begin
          state_nxt = pcolenc_pkg::ST_IDLE;
        end
      end
      pcolenc_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = pcolenc_pkg::ST_EXEC;
        end
      end
      pcolenc_pkg::ST_EXEC: begin
        if (!status.out_hold) begin
          state_nxt = pcolenc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pcolenc_pkg::ST_CLEAR;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      pcolenc_pkg::ST_CLEAR: begin
        cmd.clr_we = 1'b1;
      end
      pcolenc_pkg::ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      pcolenc_pkg::ST_EXEC: begin
        cmd.exec = !status.out_hold;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ hw/rtl/pcolenc_dp.sv @@
module pcolenc_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pcolenc_pkg::cmd_t     cmd,
  output pcolenc_pkg::status_t  status,
  input  logic                 in_req_type,
  input  logic [2:0]           in_reg_addr,
  input  logic [7:0]           in_wdata,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_rdata,
  output logic [2:0]           out_dot_clock_divider,
  output logic [8:0]           out_lines_per_frame,
  output logic                 out_gray_mode
);

  localparam int unsigned AW = pcolenc_pkg::PTR_W;
  localparam int unsigned EW = pcolenc_pkg::ENTRY_W;

  // Palette memory.
  logic [EW-1:0] mem [pcolenc_pkg::PALETTE_ENTRIES];

  // Captured transaction.
  logic          req_type_r;
  logic [2:0]    reg_addr_r;
  logic [7:0]    wdata_r;
  logic [EW-1:0] rd_word_r;

  // Architectural state.
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [1:0]    div_sel_r, div_sel_nxt;
  logic          long_r, long_nxt;
  logic          gray_r, gray_nxt;
  logic [AW-1:0] clr_cnt_r;

  // Output register.
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_rdata_r;
  logic [2:0]    out_div_r;
  logic [8:0]    out_lines_r;
  logic          out_gray_r;

  // Commit-side values.
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic          ent_we;
  logic [EW-1:0] ent_new;
  logic [7:0]    rdata;

  // Capture the transaction and read the entry at the pointer.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_type_r <= in_req_type;
      reg_addr_r <= in_reg_addr;
      wdata_r    <= in_wdata;
      rd_word_r  <= mem[ptr_r];
    end
  end

  // Register decode and state update for the committed transaction.
  always_comb begin
    ptr_nxt     = ptr_r;
    div_sel_nxt = div_sel_r;
    long_nxt    = long_r;
    gray_nxt    = gray_r;
    ent_we      = 1'b0;
    ent_new     = rd_word_r;
    rdata       = pcolenc_pkg::RDATA_IDLE;
    if (req_type_r == pcolenc_pkg::REQ_WRITE) begin
      unique case (reg_addr_r)
        pcolenc_pkg::REG_CTRL: begin
          div_sel_nxt = wdata_r[1:0];
          long_nxt    = wdata_r[2];
          gray_nxt    = wdata_r[7];
        end
        pcolenc_pkg::REG_PTR_LO: begin
          ptr_nxt[7:0] = wdata_r;
        end
        pcolenc_pkg::REG_PTR_HI: begin
          ptr_nxt[8] = wdata_r[0];
        end
        pcolenc_pkg::REG_DATA_LO: begin
          ent_we  = 1'b1;
          ent_new = {rd_word_r[EW-1], wdata_r};
        end
        pcolenc_pkg::REG_DATA_HI: begin
          ent_we  = 1'b1;
          ent_new = {wdata_r[0], rd_word_r[7:0]};
          ptr_nxt = ptr_r + AW'(1);
        end
        default: begin
          ent_we = 1'b0;
        end
      endcase
    end else begin
      unique case (reg_addr_r)
        pcolenc_pkg::REG_DATA_LO: begin
          rdata = rd_word_r[7:0];
        end
        pcolenc_pkg::REG_DATA_HI: begin
          rdata   = pcolenc_pkg::RDATA_HI_BASE | {7'd0, rd_word_r[EW-1]};
          ptr_nxt = ptr_r + AW'(1);
        end
        default: begin
          rdata = pcolenc_pkg::RDATA_IDLE;
        end
      endcase
    end
  end

  // Memory write port is shared by the clear sweep and the commit.
  assign mem_we    = cmd.clr_we || (cmd.exec && ent_we);
  assign mem_waddr = cmd.clr_we ? clr_cnt_r : ptr_r;
  assign mem_wdata = cmd.clr_we ? '0 : ent_new;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // Control state and the clear sweep counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r     <= '0;
      div_sel_r <= pcolenc_pkg::DIV_SEL_4;
      long_r    <= 1'b0;
      gray_r    <= 1'b0;
      clr_cnt_r <= '0;
    end else begin
      if (cmd.exec) begin
        ptr_r     <= ptr_nxt;
        div_sel_r <= div_sel_nxt;
        long_r    <= long_nxt;
        gray_r    <= gray_nxt;
      end
      if (cmd.clr_we) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
    end
  end

  // Output register: loaded on commit, emptied when the transaction is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_rdata_r <= rdata;
      out_div_r   <= pcolenc_pkg::divider_value(div_sel_nxt);
      out_lines_r <= long_nxt ? pcolenc_pkg::LINES_LONG : pcolenc_pkg::LINES_SHORT;
      out_gray_r  <= gray_nxt;
    end
  end

  assign status.clr_last = (clr_cnt_r == AW'(pcolenc_pkg::PALETTE_ENTRIES - 1));
  assign status.out_hold = out_valid_r && out_stall;

  assign out_valid             = out_valid_r;
  assign out_rdata             = out_rdata_r;
  assign out_dot_clock_divider = out_div_r;
  assign out_lines_per_frame   = out_lines_r;
  assign out_gray_mode         = out_gray_r;

endmodule

@@ hw/rtl/palette_color_encoder_regs.sv @@
// An accepted transaction is captured along with the palette entry at the pointer;
// a commit then updates the registers and the entry and loads the output register.
// A new transaction is taken only after the previous one is committed, since each
// access reads and then writes the palette memory; a held result delays the commit.
// Reset: synchronous, active low. After reset the palette is cleared by a
// sweep of all 512 entries, one entry per cycle, during which in_stall is high.
module palette_color_encoder_regs (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_req_type,
  input  logic [2:0] in_reg_addr,
  input  logic [7:0] in_wdata,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_rdata,
  output logic [2:0] out_dot_clock_divider,
  output logic [8:0] out_lines_per_frame,
  output logic       out_gray_mode
);

  pcolenc_pkg::cmd_t    cmd;
  pcolenc_pkg::status_t status;

  // Controller.
  pcolenc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  // Datapath with the palette memory and the register file.
  pcolenc_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .status                (status),
    .in_req_type           (in_req_type),
    .in_reg_addr           (in_reg_addr),
    .in_wdata              (in_wdata),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_rdata             (out_rdata),
    .out_dot_clock_divider (out_dot_clock_divider),
    .out_lines_per_frame   (out_lines_per_frame),
    .out_gray_mode         (out_gray_mode)
  );

  // No transaction is taken while the palette is being cleared.
  a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_we |-> in_stall)
    else $error("input accepted during palette clear");

  // An accepted transaction blocks the input on the next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("back-to-back accept");

  // A commit always presents a result on the next cycle.
  a_commit_output: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid)
    else $error("commit did not load the output register");

  // A commit never overwrites a result that is still held.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> !(out_valid && out_stall))
    else $error("held result overwritten");

endmodule

@@ sim/palette_color_encoder_regs_tb.sv @@
module palette_color_encoder_regs_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Register selects that the package leaves unnamed; accesses to them do nothing.
  localparam logic [2:0] REG_SPARE_1 = 3'd1;
  localparam logic [2:0] REG_SPARE_6 = 3'd6;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;

  localparam int unsigned PALETTE_SIZE = 512;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned MAX_PRINTS   = 40;

  // One expected result transaction.
  typedef struct packed {
    logic [7:0] rdata;
    logic [2:0] divider;
    logic [8:0] lines;
    logic       gray;
  } encoder_result_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic       in_req_type;
  logic [2:0] in_reg_addr;
  logic [7:0] in_wdata;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_rdata;
  logic [2:0] out_dot_clock_divider;
  logic [8:0] out_lines_per_frame;
  logic       out_gray_mode;

  // Shadow copy of the encoder state, advanced on every accepted transaction.
  logic [8:0] shadow_palette [PALETTE_SIZE];
  logic [8:0] shadow_pointer;
  logic [1:0] shadow_div_sel;
  logic       shadow_long_frame;
  logic       shadow_gray;

  encoder_result_t pending_results[$];

  int unsigned mismatches      = 0;
  int unsigned accesses_sent   = 0;
  int unsigned accesses_taken  = 0;
  int unsigned results_checked = 0;
  int unsigned cycle_count     = 0;
  int unsigned send_idle_pct   = 0;
  int unsigned recv_stall_pct  = 0;
  int unsigned hold_left       = 0;

  palette_color_encoder_regs dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_req_type           (in_req_type),
    .in_reg_addr           (in_reg_addr),
    .in_wdata              (in_wdata),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_rdata             (out_rdata),
    .out_dot_clock_divider (out_dot_clock_divider),
    .out_lines_per_frame   (out_lines_per_frame),
    .out_gray_mode         (out_gray_mode)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Applies one bus access to the shadow state and returns the result it produces.
  function automatic encoder_result_t apply_access(input logic req, input logic [2:0] sel,
                                                   input logic [7:0] data);
    encoder_result_t res;
    logic [8:0] ptr;
    ptr = shadow_pointer;
    res.rdata = pcolenc_pkg::RDATA_IDLE;
    if (req == pcolenc_pkg::REQ_WRITE) begin
      case (sel)
        pcolenc_pkg::REG_CTRL: begin
          shadow_div_sel    = data[1:0];
          shadow_long_frame = data[2];
          shadow_gray       = data[7];
        end
        pcolenc_pkg::REG_PTR_LO: shadow_pointer = {ptr[8], data};
        pcolenc_pkg::REG_PTR_HI: shadow_pointer = {data[0], ptr[7:0]};
        pcolenc_pkg::REG_DATA_LO: shadow_palette[ptr] = {shadow_palette[ptr][8], data};
        pcolenc_pkg::REG_DATA_HI: begin
          shadow_palette[ptr] = {data[0], shadow_palette[ptr][7:0]};
          shadow_pointer = ptr + 9'd1;
        end
        default: ;
      endcase
    end else begin
      case (sel)
        pcolenc_pkg::REG_DATA_LO: res.rdata = shadow_palette[ptr][7:0];
        pcolenc_pkg::REG_DATA_HI: begin
          res.rdata = pcolenc_pkg::RDATA_HI_BASE | {7'd0, shadow_palette[ptr][8]};
          shadow_pointer = ptr + 9'd1;
        end
        default: res.rdata = pcolenc_pkg::RDATA_IDLE;
      endcase
    end
    case (shadow_div_sel)
      pcolenc_pkg::DIV_SEL_4: res.divider = 3'd4;
      pcolenc_pkg::DIV_SEL_3: res.divider = 3'd3;
      default:                res.divider = 3'd2;
    endcase
    res.lines = shadow_long_frame ? pcolenc_pkg::LINES_LONG : pcolenc_pkg::LINES_SHORT;
    res.gray  = shadow_gray;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("mismatch %0d at cycle %0d: %s got 0x%0h, expected 0x%0h",
               mismatches, cycle_count, what, got, want);
  endtask

  // Check each result transaction against the oldest expectation, then record the
  // expectation for any access accepted at this edge.
  always @(posedge clk) begin
    encoder_result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending, rdata", out_rdata, 0);
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          if (out_rdata !== want.rdata)
            report_mismatch("rdata", out_rdata, want.rdata);
          if (out_dot_clock_divider !== want.divider)
            report_mismatch("dot_clock_divider", out_dot_clock_divider, want.divider);
          if (out_lines_per_frame !== want.lines)
            report_mismatch("lines_per_frame", out_lines_per_frame, want.lines);
          if (out_gray_mode !== want.gray)
            report_mismatch("gray_mode", out_gray_mode, want.gray);
        end
      end
      if (in_valid && !in_stall) begin
        pending_results.push_back(apply_access(in_req_type, in_reg_addr, in_wdata));
        accesses_taken++;
      end
    end
  end

  // Receiver: a long hold-off when one is requested, random stalls otherwise.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Run limit in case the block hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results pending",
               cycle_count, pending_results.size());
      $display("tb: failure");
      $finish;
    end
  end

  // Offers one access, with random idle cycles ahead of it, and waits until it is taken.
  task automatic send_access(input logic req, input logic [2:0] sel, input logic [7:0] data);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid    = 1'b1;
    in_req_type = req;
    in_reg_addr = sel;
    in_wdata    = data;
    accesses_sent++;
    do @(posedge clk); while (in_stall);
  endtask

  // Drops valid and waits until every expected result has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Every register read straight after reset, then writes to the spare registers.
  task automatic test_reset_state();
    for (int r = 0; r < 8; r++) send_access(pcolenc_pkg::REQ_READ, r[2:0], 8'h00);
    send_access(pcolenc_pkg::REQ_WRITE, REG_SPARE_1, 8'hFF);
    send_access(pcolenc_pkg::REQ_WRITE, REG_SPARE_6, 8'hFF);
    send_access(pcolenc_pkg::REQ_WRITE, REG_SPARE_7, 8'h00);
  endtask

  // Every divider select, both frame lengths and both gray settings.
  task automatic test_control_register();
    send_access(pcolenc_pkg::REQ_WRITE, pcolenc_pkg::REG_CTRL, 8'hFF);
    send_access(pcolenc_pkg::REQ_WRITE, pcolenc_pkg::REG_CTRL, 8'h01);
    send_access(pcolenc_pkg::REQ_WRITE, pcolenc_pkg::REG_CTRL, 8'h02);
    send_access(pcolenc_pkg::REQ_WRITE, pcolenc_pkg::REG_CTRL, 8'h00);
  endtask

  // Pointer at the top entry, high write ignoring the upper bits, wrap to zero.
  task automatic test_palette_wrap();
    send_access(pcolenc_pkg::REQ_WRITE, pcolenc_pkg::REG_PTR_LO, 8'hFF);
    send_access(pcolenc_pkg::REQ_WRITE, pcolenc_pkg::REG_PTR_HI, 8'hFF);
    send_access(pcolenc_pkg::REQ_WRITE, pcolenc_pkg::REG_DATA_LO, 8'h00);
    send_access(pcolenc_pkg::REQ_WRITE, pcolenc_pkg::REG_DATA_HI, 8'hFF);
    send_access(pcolenc_pkg::REQ_WRITE, pcolenc_pkg::REG_PTR_LO, 8'hFF);
    send_access(pcolenc_pkg::REQ_WRITE, pcolenc_pkg::REG_PTR_HI, 8'h01);
    send_access(pcolenc_pkg::REQ_READ, pcolenc_pkg::REG_DATA_LO, 8'hFF);
    send_access(pcolenc_pkg::REQ_READ, pcolenc_pkg::REG_DATA_HI, 8'h00);
    send_access(pcolenc_pkg::REQ_READ, pcolenc_pkg::REG_DATA_LO, 8'h00);
  endtask

  // One short piece of bus traffic: mostly well-formed palette sequences,
  // with some control writes and some random accesses.
  task automatic send_random_sequence();
    int unsigned kind;
    int unsigned burst;
    logic [8:0] ptr;
    logic [7:0] hi_byte;
    kind  = $urandom_range(99);
    burst = $urandom_range(8, 1);
    if (kind < 20) begin
      ptr = ($urandom_range(3) == 0) ? 9'h1FF - 9'($urandom_range(3)) : 9'($urandom);
      hi_byte = 8'($urandom);
      hi_byte[0] = ptr[8];
      send_access(pcolenc_pkg::REQ_WRITE, pcolenc_pkg::REG_PTR_LO, ptr[7:0]);
      send_access(pcolenc_pkg::REQ_WRITE, pcolenc_pkg::REG_PTR_HI, hi_byte);
    end else if (kind < 48) begin
      for (int i = 0; i < burst; i++) begin
        if ($urandom_range(7) != 0)
          send_access(pcolenc_pkg::REQ_WRITE, pcolenc_pkg::REG_DATA_LO, 8'($urandom));
        send_access(pcolenc_pkg::REQ_WRITE, pcolenc_pkg::REG_DATA_HI, 8'($urandom));
      end
    end else if (kind < 75) begin
      for (int i = 0; i < burst; i++) begin
        if ($urandom_range(7) != 0)
          send_access(pcolenc_pkg::REQ_READ, pcolenc_pkg::REG_DATA_LO, 8'($urandom));
        send_access(pcolenc_pkg::REQ_READ, pcolenc_pkg::REG_DATA_HI, 8'($urandom));
      end
    end else if (kind < 85) begin
      send_access(pcolenc_pkg::REQ_WRITE, pcolenc_pkg::REG_CTRL, 8'($urandom));
    end else begin
      send_access(1'($urandom), 3'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_random_traffic(input int unsigned count);
    int unsigned target;
    target = accesses_sent + count;
    while (accesses_sent < target) send_random_sequence();
  endtask

  // Hold the result side for a long stretch while accesses keep coming, so the
  // block fills and stalls its input.
  task automatic test_output_backpressure();
    hold_left = HOLD_CYCLES;
    test_random_traffic(60);
    wait_drained();
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_req_type = pcolenc_pkg::REQ_READ;
    in_reg_addr = pcolenc_pkg::REG_CTRL;
    in_wdata    = 8'h00;
    out_stall   = 1'b0;
    foreach (shadow_palette[i]) shadow_palette[i] = '0;
    shadow_pointer    = '0;
    shadow_div_sel    = pcolenc_pkg::DIV_SEL_4;
    shadow_long_frame = 1'b0;
    shadow_gray       = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Sender rarely idle, receiver often stalled.
    send_idle_pct  = 6;
    recv_stall_pct = 47;
    test_reset_state();
    test_control_register();
    test_palette_wrap();
    test_random_traffic(380);
    wait_drained();

    // Sender often idle, receiver rarely stalled.
    send_idle_pct  = 47;
    recv_stall_pct = 6;
    test_random_traffic(380);
    wait_drained();

    // No idling on either side.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_output_backpressure();
    test_random_traffic(330);
    wait_drained();

    repeat (10) @(posedge clk);
    $display("summary: %0d accesses taken, %0d results checked across three idle patterns",
             accesses_taken, results_checked);
    $display("summary: covered all registers, pointer wrap and a %0d-cycle output hold",
             HOLD_CYCLES);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
